@@ rtl/sofp_pkg.sv @@
`default_nettype none
package sofp_pkg;

	localparam int unsigned MAX_BLOCKS = 4;
	localparam logic [7:0] MaxBlocksByte = 8'(MAX_BLOCKS);

	localparam int unsigned IN_DATA_W = 8;
	localparam int unsigned OUT_DATA_W = 80;
	localparam int unsigned OUT_USER_W = 3;

	localparam logic [1:0] PH_COUNT = 2'd0;
	localparam logic [1:0] PH_START = 2'd1;
	localparam logic [1:0] PH_END = 2'd2;

	localparam logic [2:0] ST_BLOCK = 3'd0;
	localparam logic [2:0] ST_EMPTY = 3'd1;
	localparam logic [2:0] ST_BAD_COUNT = 3'd2;
	localparam logic [2:0] ST_BAD_PREFIX = 3'd3;
	localparam logic [2:0] ST_TRUNCATED = 3'd4;

	localparam logic [7:0] PREFIX_FULL = 8'hff;
	localparam logic [7:0] MASK_6 = 8'h3f;
	localparam logic [7:0] MASK_5 = 8'h1f;

	typedef struct packed {
		logic [1:0]  phase;
		logic [2:0]  blocks_announced;
		logic [1:0]  current_block;
		logic [2:0]  field_length;
		logic [2:0]  field_bytes_seen;
		logic [31:0] field_accumulator;
		logic [31:0] saved_start;
		logic [5:0]  consumed_count;
	} state_t;

	typedef struct packed {
		logic        valid;
		logic [2:0]  status;
		logic [1:0]  block_index;
		logic [31:0] block_start_bits;
		logic [31:0] block_end_bits;
		logic [2:0]  block_total;
		logic [5:0]  bytes_used;
		logic        option_done;
	} result_t;

	localparam state_t STATE_CLEAR = '{
		phase: PH_COUNT,
		blocks_announced: 3'd0,
		current_block: 2'd0,
		field_length: 3'd0,
		field_bytes_seen: 3'd0,
		field_accumulator: 32'd0,
		saved_start: 32'd0,
		consumed_count: 6'd0
	};

endpackage
`default_nettype wire

@@ rtl/sofp_step.sv @@
`default_nettype none
module sofp_step (
	input  wire sofp_pkg::state_t  cur,
	input  wire logic [7:0]        data_byte,
	input  wire logic              end_of_data,
	output sofp_pkg::state_t       nxt,
	output sofp_pkg::result_t      res
);
	import sofp_pkg::*;

	logic [5:0]  used;
	logic [31:0] acc_shift;
	logic [2:0]  seen_inc;
	logic [2:0]  block_inc;
	logic        err;
	logic [2:0]  err_status;
	logic [1:0]  err_index;
	logic [2:0]  err_total;

	always_comb begin
		used = cur.consumed_count + 6'd1;
		acc_shift = {cur.field_accumulator[23:0], data_byte};
		seen_inc = cur.field_bytes_seen + 3'd1;
		block_inc = {1'b0, cur.current_block} + 3'd1;
		nxt = cur;
		nxt.consumed_count = used;
		res = '0;
		err = 1'b0;
		err_status = ST_TRUNCATED;
		err_index = cur.current_block;
		err_total = cur.blocks_announced;

		if (cur.phase != PH_START && cur.phase != PH_END) begin
			used = 6'd1;
			nxt.consumed_count = 6'd1;
			if (data_byte > MaxBlocksByte) begin
				err = 1'b1;
				err_status = ST_BAD_COUNT;
				err_index = 2'd0;
				err_total = 3'd0;
			end else if (data_byte == 8'd0) begin
				nxt = STATE_CLEAR;
				res.valid = 1'b1;
				res.status = ST_EMPTY;
				res.bytes_used = 6'd1;
				res.option_done = 1'b1;
			end else begin
				nxt.blocks_announced = data_byte[2:0];
				nxt.current_block = 2'd0;
				nxt.field_bytes_seen = 3'd0;
				if (end_of_data) begin
					err = 1'b1;
					err_index = 2'd0;
					err_total = data_byte[2:0];
				end else begin
					nxt.phase = PH_START;
				end
			end
		end else if (cur.field_bytes_seen == 3'd0) begin
			nxt.field_bytes_seen = 3'd1;
			if (end_of_data) begin
				err = 1'b1;
			end else if (!data_byte[7]) begin
				nxt.field_length = 3'd2;
				nxt.field_accumulator = {24'd0, data_byte};
			end else if (!data_byte[6]) begin
				nxt.field_length = 3'd3;
				nxt.field_accumulator = {24'd0, data_byte & MASK_6};
			end else if (!data_byte[5]) begin
				nxt.field_length = 3'd4;
				nxt.field_accumulator = {24'd0, data_byte & MASK_5};
			end else if (data_byte == PREFIX_FULL) begin
				nxt.field_length = 3'd5;
				nxt.field_accumulator = 32'd0;
			end else begin
				err = 1'b1;
				err_status = ST_BAD_PREFIX;
			end
		end else begin
			nxt.field_accumulator = acc_shift;
			nxt.field_bytes_seen = seen_inc;
			if (seen_inc < cur.field_length) begin
				err = end_of_data;
			end else begin
				nxt.field_bytes_seen = 3'd0;
				if (cur.phase == PH_START) begin
					nxt.saved_start = acc_shift;
					if (end_of_data) begin
						err = 1'b1;
					end else begin
						nxt.phase = PH_END;
					end
				end else begin
					res.status = ST_BLOCK;
					res.block_index = cur.current_block;
					res.block_start_bits = cur.saved_start;
					res.block_end_bits = acc_shift;
					res.block_total = cur.blocks_announced;
					res.bytes_used = used;
					if (block_inc >= cur.blocks_announced) begin
						nxt = STATE_CLEAR;
						res.valid = 1'b1;
						res.option_done = 1'b1;
					end else if (end_of_data) begin
						err = 1'b1;
					end else begin
						nxt.current_block = block_inc[1:0];
						nxt.phase = PH_START;
						res.valid = 1'b1;
					end
				end
			end
		end

		if (err) begin
			nxt = STATE_CLEAR;
			res.valid = 1'b1;
			res.status = err_status;
			res.block_index = err_index;
			res.block_start_bits = 32'd0;
			res.block_end_bits = 32'd0;
			res.block_total = err_total;
			res.bytes_used = used;
			res.option_done = 1'b1;
		end
	end

endmodule
`default_nettype wire

@@ rtl/sack_option_field_parser.sv @@
// a byte sits in the input register, its result in the output register
// throughput: one byte per cycle unless output stalls; state updates once per byte
// the input register advances whenever the result register is empty or being taken
// arst_n clears the parser state and both valid flags at once
`default_nettype none
module sack_option_field_parser (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// data_byte
	input  wire logic [sofp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// end_of_data
	input  wire logic                                s_axis_tlast,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// block_index, block_start_bits, block_end_bits, block_total, bytes_used, zero pad
	output logic [sofp_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
	// status
	output logic [sofp_pkg::OUT_USER_W-1:0]          m_axis_tuser,
	// option_done
	output logic                                     m_axis_tlast
);
	import sofp_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        advance;
	state_t      st_q;
	state_t      st_nxt;
	result_t     res;
	logic        out_valid_q;
	result_t     out_q;

	sofp_step u_step (
		.cur         (st_q),
		.data_byte   (byte_s1),
		.end_of_data (last_s1),
		.nxt         (st_nxt),
		.res         (res)
	);

	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata[7:0];
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_CLEAR;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = out_q.status;
	assign m_axis_tlast = out_q.option_done;
	assign m_axis_tdata = {5'd0, out_q.bytes_used, out_q.block_total, out_q.block_end_bits,
		out_q.block_start_bits, out_q.block_index};

	// count phase never holds a partial field
	a_count_no_field: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_COUNT) |-> (st_q.field_bytes_seen == 3'd0))
		else $error("partial field in count phase");

	// every non-block status ends the option
	a_error_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != ST_BLOCK) |-> m_axis_tlast)
		else $error("error result without option end");

	// block position stays inside the announced count
	a_block_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_START || st_q.phase == PH_END)
		|-> ({1'b0, st_q.current_block} < st_q.blocks_announced))
		else $error("block index beyond announced count");

	// a field in progress never reaches its length
	a_field_len: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.field_bytes_seen != 3'd0) |-> (st_q.field_bytes_seen < st_q.field_length))
		else $error("field byte count overran field length");

endmodule
`default_nettype wire
